/* rtl/core/gpb_pkg.sv */
// Package for the GPIO port and blink controller: constants, command and
// register codes, transaction structs and the pin drive helpers.
// Used by gpb_blink_ram and gpio_port_blink_controller.
package gpb_pkg;

    localparam int PIN_COUNT = 16;
    localparam int TIME_BITS = 16;
    localparam int IDX_W     = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam int CNT_W     = $clog2(PIN_COUNT + 1);

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [PIN_COUNT-1:0] t_pins;
    typedef logic [TIME_BITS-1:0] t_time;

    localparam t_time TMAX     = '1;
    localparam t_idx  LAST_IDX = t_idx'(PIN_COUNT - 1);

    typedef enum logic [2:0] {
        CMD_WRITE_PIN   = 3'd0,
        CMD_WRITE_MASK  = 3'd1,
        CMD_READ_PIN    = 3'd2,
        CMD_SAMPLE      = 3'd3,
        CMD_START_BLINK = 3'd4,
        CMD_STOP_BLINK  = 3'd5,
        CMD_TICK        = 3'd6,
        CMD_QUERY_BLINK = 3'd7
    } t_cmd;

    typedef enum logic {
        REG_DIRECTION = 1'b0,
        REG_INVERT    = 1'b1
    } t_reg;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  port;
        logic        value;
        logic [15:0] out_mask;
        logic [15:0] pin_levels;
        logic [15:0] on_time;
        logic [15:0] off_time;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pins;
        logic [15:0] changed;
        logic        bit_value;
        logic        ok;
    } t_out_item;

    // One blink table entry
    typedef struct packed {
        logic  phase;
        t_time elapsed;
        t_time on_ticks;
        t_time off_ticks;
    } t_blink;

    typedef struct packed {
        logic  ok;
        t_pins word;
    } t_drive;

    function automatic t_time sat_time(logic [15:0] t);
        logic [31:0] t32;
        t32 = 32'(t);
        if (t32 > 32'(TMAX)) begin
            return TMAX;
        end
        return TIME_BITS'(t32);
    endfunction

    // Write one pin with inversion if it is an output, forcing input pins high.
    function automatic t_drive drive_pin(t_pins word, t_pins dir, t_pins inv,
                                         t_idx idx, logic level);
        t_drive r;
        r.ok   = dir[idx];
        r.word = word;
        if (dir[idx]) begin
            r.word      = word | ~dir;
            r.word[idx] = level ^ inv[idx];
        end
        return r;
    endfunction

endpackage

/* rtl/core/gpb_blink_ram.sv */
// Blink table storage: one entry per pin, one write and one registered read
// port. Depends on gpb_pkg for the entry and index types.
module gpb_blink_ram (
    input  logic           i_clk,
    input  logic           i_we,
    input  gpb_pkg::t_idx   i_waddr,
    input  gpb_pkg::t_blink i_wdata,
    input  logic           i_re,
    input  gpb_pkg::t_idx   i_raddr,
    output gpb_pkg::t_blink o_rdata
);
    import gpb_pkg::*;

    t_blink r_mem [PIN_COUNT];
    t_blink r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/gpio_port_blink_controller.sv */
// GPIO port with direction and invert masks and a per-pin blink engine.
// Pin, mask, read, sample and query go from accept to S_DONE, then to
// o_out_valid; start and stop blink pass S_PIN first (one blink table read);
// tick walks the table in S_TICK, one table entry per cycle, before S_DONE.
// One transaction in flight at a time; the result register frees the input.
// Synchronous active-low reset: pin word all ones, masks and blink flags zero.
module gpio_port_blink_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gpb_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gpb_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import gpb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PIN  = 4'b0010,
        S_TICK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state    r_state, n_state;
    t_pins     r_dir, r_inv;
    t_pins     r_pins, n_pins;
    t_pins     r_active, n_active;
    t_cnt      r_cnt, n_cnt;
    logic      r_rv;
    t_idx      r_rv_idx;
    logic [15:0] r_changed, n_changed;
    logic      r_bit, n_bit;
    logic      r_ok, n_ok;
    logic      r_out_vld;
    t_out_item r_out;
    t_in_item  r_in;

    logic      acc;
    logic      in_p_ok;
    t_idx      in_p;
    t_pins     lv, lev;
    t_drive    drv;
    t_time     el_inc, target;
    logic      rd_en, wr_en;
    t_idx      rd_addr, wr_addr;
    t_blink    rd_data, wr_data;
    logic      load_out;

    gpb_blink_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign acc      = i_in_valid && (r_state == S_IDLE);
    assign in_p_ok  = 32'(i_in_data.port) < PIN_COUNT;
    assign in_p     = in_p_ok ? t_idx'(i_in_data.port) : '0;
    assign load_out = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);

    always_comb begin
        n_state   = r_state;
        n_pins    = r_pins;
        n_active  = r_active;
        n_changed = r_changed;
        n_bit     = r_bit;
        n_ok      = r_ok;
        n_cnt     = r_cnt;
        rd_en     = 1'b0;
        rd_addr   = in_p;
        wr_en     = 1'b0;
        wr_addr   = r_rv_idx;
        wr_data   = rd_data;
        lv        = PIN_COUNT'(i_in_data.out_mask) ^ r_inv;
        lev       = PIN_COUNT'(i_in_data.pin_levels);
        drv       = '0;
        el_inc    = (rd_data.elapsed == TMAX) ? rd_data.elapsed
                                              : rd_data.elapsed + t_time'(1);
        target    = rd_data.phase ? rd_data.on_ticks : rd_data.off_ticks;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_changed = '0;
                    n_bit     = 1'b0;
                    n_ok      = 1'b1;
                    n_state   = S_DONE;
                    case (t_cmd'(i_in_data.cmd))
                        CMD_WRITE_PIN: begin
                            if (in_p_ok) begin
                                drv    = drive_pin(r_pins, r_dir, r_inv, in_p,
                                                   i_in_data.value);
                                n_pins = drv.word;
                                n_ok   = drv.ok;
                            end else begin
                                n_ok = 1'b0;
                            end
                        end
                        CMD_WRITE_MASK: begin
                            n_pins = (lv & r_dir) | ~r_dir;
                        end
                        CMD_READ_PIN: begin
                            if (in_p_ok) begin
                                n_bit = r_pins[in_p] ^ r_inv[in_p];
                            end else begin
                                n_ok = 1'b0;
                            end
                        end
                        CMD_SAMPLE: begin
                            n_changed = 16'(r_pins ^ lev);
                            n_pins    = lev;
                        end
                        CMD_START_BLINK, CMD_STOP_BLINK: begin
                            if (in_p_ok) begin
                                rd_en   = 1'b1;
                                n_state = S_PIN;
                            end else begin
                                n_ok = 1'b0;
                            end
                        end
                        CMD_TICK: begin
                            n_cnt   = '0;
                            n_state = S_TICK;
                        end
                        default: begin
                            if (in_p_ok) begin
                                n_bit = r_active[in_p];
                            end else begin
                                n_ok = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_PIN: begin
                // Entry read at accept is on rd_data now
                if (t_cmd'(r_in.cmd) == CMD_START_BLINK) begin
                    wr_en             = 1'b1;
                    wr_data.on_ticks  = sat_time(r_in.on_time);
                    wr_data.off_ticks = sat_time(r_in.off_time);
                    if (!r_active[r_rv_idx]) begin
                        wr_data.phase       = 1'b1;
                        wr_data.elapsed     = '0;
                        n_active[r_rv_idx]  = 1'b1;
                        drv    = drive_pin(r_pins, r_dir, r_inv, r_rv_idx, 1'b1);
                        n_pins = drv.word;
                        n_ok   = drv.ok;
                    end
                end else begin
                    if (!r_active[r_rv_idx]) begin
                        n_ok = 1'b0;
                    end else begin
                        n_active[r_rv_idx] = 1'b0;
                        drv    = drive_pin(r_pins, r_dir, r_inv, r_rv_idx, 1'b0);
                        n_pins = drv.word;
                        n_ok   = drv.ok;
                    end
                end
                n_state = S_DONE;
            end
            S_TICK: begin
                // Read entry r_cnt while updating the entry read last cycle
                if (r_cnt < CNT_W'(PIN_COUNT)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_cnt[IDX_W-1:0];
                    n_cnt   = r_cnt + t_cnt'(1);
                end
                if (r_rv && r_active[r_rv_idx]) begin
                    wr_en = 1'b1;
                    if (el_inc >= target) begin
                        wr_data.phase   = ~rd_data.phase;
                        wr_data.elapsed = '0;
                        drv    = drive_pin(r_pins, r_dir, r_inv, r_rv_idx,
                                           ~rd_data.phase);
                        n_pins = drv.word;
                    end else begin
                        wr_data.elapsed = el_inc;
                    end
                end
                if (r_rv && (r_rv_idx == LAST_IDX)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Force the new input pins high on a direction write
        if (i_cfg_we && (t_reg'(i_cfg_idx) == REG_DIRECTION)) begin
            n_pins = n_pins | ~PIN_COUNT'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dir     <= '0;
            r_inv     <= '0;
            r_pins    <= '1;
            r_active  <= '0;
            r_cnt     <= '0;
            r_rv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pins   <= n_pins;
            r_active <= n_active;
            r_cnt    <= n_cnt;
            r_rv     <= rd_en;
            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_idx))
                    REG_DIRECTION: begin
                        r_dir <= PIN_COUNT'(i_cfg_data);
                    end
                    REG_INVERT: begin
                        r_inv <= PIN_COUNT'(i_cfg_data);
                    end
                    default: begin
                        r_inv <= r_inv;
                    end
                endcase
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rv_idx  <= rd_addr;
        r_changed <= n_changed;
        r_bit     <= n_bit;
        r_ok      <= n_ok;
        if (acc) begin
            r_in <= i_in_data;
        end
        if (load_out) begin
            r_out.pins      <= 16'(r_pins);
            r_out.changed   <= r_changed;
            r_out.bit_value <= r_bit;
            r_out.ok        <= r_ok;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_pin_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PIN) |-> r_rv)
        else $error("blink entry not read for pin command");

    a_read_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv |-> (r_state == S_PIN || r_state == S_TICK))
        else $error("table read data outside pin or tick work");

    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!r_rv && !rd_en))
        else $error("table access after transaction finished");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PIN && t_cmd'(r_in.cmd) == CMD_STOP_BLINK)
        |=> !r_active[$past(r_rv_idx)])
        else $error("stop left blink active");

    a_dir_forces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && t_reg'(i_cfg_idx) == REG_DIRECTION && r_state == S_IDLE
         && !i_in_valid) |=> ((r_pins | r_dir) == '1))
        else $error("input pins not forced high after direction write");

endmodule
